FILE: hdl/vdp_pkg.sv
// ---------------------------------------------------------------------------
// vdp_pkg
// Shared types and constants for the display processor host port.
// ---------------------------------------------------------------------------
package vdp_pkg;

    localparam int ADDR_BITS_DEFAULT = 14;
    localparam int PTR_LOAD_BITS     = 14;   // width of a pointer load from the latch
    localparam int NUM_REGS          = 8;

    localparam logic [7:0] CTRL_REG_SEL  = 8'h80;  // second byte: register write
    localparam logic [7:0] STATUS_IRQ    = 8'h80;  // status interrupt flag
    localparam logic [7:0] REG1_IRQ_EN   = 8'h20;  // register 1 interrupt enable
    localparam logic [7:0] ADDR_HI_MASK  = 8'h3F;

    typedef enum logic [2:0] {
        OP_DATA_WR   = 3'd0,
        OP_DATA_RD   = 3'd1,
        OP_CTRL_WR   = 3'd2,
        OP_STATUS_RD = 3'd3,
        OP_FLAGS     = 3'd4
    } op_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } vram_ctrl_t;

    typedef struct packed {
        logic       rd_mem;      // read data comes from video memory
        logic [7:0] rd_byte;     // status byte, or zero
        logic       reg_written;
        logic [2:0] reg_number;
        logic [7:0] reg_value;
        logic       irq;
    } vdp_result_t;

endpackage

FILE: hdl/vdp_host_port_with_vram.sv
// ---------------------------------------------------------------------------
// vdp_host_port_with_vram
// Host side of a video display processor: data and control ports, status,
// control registers and a 2^ADDR_BITS byte video memory.
// ---------------------------------------------------------------------------
// The result is valid in the cycle after acceptance (output register, and
//   registered memory read data for data reads).
// Throughput: one item per cycle; s_ready is high while the result register
//   is empty or being taken.
// Reset: synchronous, active low; clears pointer, latch, registers, status
//   and the output valid. Video memory is not cleared and needs no pass.
// ---------------------------------------------------------------------------
module vdp_host_port_with_vram #(
    parameter int ADDR_BITS = vdp_pkg::ADDR_BITS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [7:0] s_data_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_reg_written,
    output logic [2:0] m_reg_number,
    output logic [7:0] m_reg_value,
    output logic       m_irq_out
);
    import vdp_pkg::*;

    logic                 accept;
    vram_ctrl_t           vram_ctrl;
    logic [ADDR_BITS-1:0] vram_addr;
    logic [7:0]           vram_rdata;
    vdp_result_t          result;
    vdp_result_t          result_reg;
    logic                 m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    vdp_host_regs #(.ADDR_BITS(ADDR_BITS)) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .operation (s_operation),
        .data_in   (s_data_in),
        .vram_ctrl (vram_ctrl),
        .vram_addr (vram_addr),
        .result    (result)
    );

    vdp_vram #(.ADDR_BITS(ADDR_BITS)) u_vram (
        .aclk  (aclk),
        .ctrl  (vram_ctrl),
        .addr  (vram_addr),
        .wdata (s_data_in),
        .rdata (vram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    // memory read data is held in the memory's own read register
    assign m_read_data   = result_reg.rd_mem ? vram_rdata : result_reg.rd_byte;
    assign m_valid       = m_valid_reg;
    assign m_reg_written = result_reg.reg_written;
    assign m_reg_number  = result_reg.reg_number;
    assign m_reg_value   = result_reg.reg_value;
    assign m_irq_out     = result_reg.irq;

endmodule

FILE: hdl/vdp_vram.sv
// ---------------------------------------------------------------------------
// vdp_vram
// Single-port video memory with registered, enabled read data.
// ---------------------------------------------------------------------------
module vdp_vram #(
    parameter int ADDR_BITS = vdp_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  vdp_pkg::vram_ctrl_t    ctrl,
    input  logic [ADDR_BITS-1:0]   addr,
    input  logic [7:0]             wdata,
    output logic [7:0]             rdata
);
    import vdp_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= wdata;
        end
        // hold read data until the next read
        if (ctrl.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/vdp_host_regs.sv
// ---------------------------------------------------------------------------
// vdp_host_regs
// Control latch, address pointer, control registers and status byte.
// Decodes one item and produces its result fields and the memory access.
// ---------------------------------------------------------------------------
module vdp_host_regs #(
    parameter int ADDR_BITS = vdp_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [2:0]             operation,
    input  logic [7:0]             data_in,
    output vdp_pkg::vram_ctrl_t    vram_ctrl,
    output logic [ADDR_BITS-1:0]   vram_addr,
    output vdp_pkg::vdp_result_t   result
);
    import vdp_pkg::*;

    logic [7:0]           regs_reg  [0:NUM_REGS-1];
    logic [7:0]           regs_next [0:NUM_REGS-1];
    logic [ADDR_BITS-1:0] ptr_reg, ptr_next;
    logic                 pending_reg, pending_next;
    logic [7:0]           latch_reg, latch_next;
    logic [7:0]           status_reg, status_next;
    logic [PTR_LOAD_BITS-1:0] ptr_load;

    assign ptr_load  = {data_in[5:0] & ADDR_HI_MASK[5:0], latch_reg};
    assign vram_addr = ptr_reg;

    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            regs_next[i] = regs_reg[i];
        end
        ptr_next           = ptr_reg;
        pending_next       = pending_reg;
        latch_next         = latch_reg;
        status_next        = status_reg;
        vram_ctrl          = '0;
        result             = '0;

        case (operation)
            OP_DATA_WR: begin
                vram_ctrl.wr_en = accept;
                ptr_next        = ptr_reg + 1'b1;
                pending_next    = 1'b0;
            end
            OP_DATA_RD: begin
                vram_ctrl.rd_en = accept;
                result.rd_mem   = 1'b1;
                ptr_next        = ptr_reg + 1'b1;
                pending_next    = 1'b0;
            end
            OP_CTRL_WR: begin
                if (!pending_reg) begin
                    latch_next   = data_in;
                    pending_next = 1'b1;
                end else begin
                    pending_next = 1'b0;
                    if ((data_in & CTRL_REG_SEL) != 8'h00) begin
                        result.reg_written = 1'b1;
                        result.reg_number  = data_in[2:0];
                        result.reg_value   = latch_reg;
                        regs_next[data_in[2:0]] = latch_reg;
                    end else begin
                        ptr_next = ptr_load[ADDR_BITS-1:0];
                    end
                end
            end
            OP_STATUS_RD: begin
                result.rd_byte = status_reg;
                status_next    = status_reg & ~STATUS_IRQ;
                pending_next   = 1'b0;
            end
            OP_FLAGS: begin
                status_next = status_reg | data_in;
            end
            default: begin
            end
        endcase

        result.irq = ((status_next & STATUS_IRQ) != 8'h00) &&
                     ((regs_next[1] & REG1_IRQ_EN) != 8'h00);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= '0;
            end
            ptr_reg     <= '0;
            pending_reg <= 1'b0;
            latch_reg   <= '0;
            status_reg  <= '0;
        end else if (accept) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= regs_next[i];
            end
            ptr_reg     <= ptr_next;
            pending_reg <= pending_next;
            latch_reg   <= latch_next;
            status_reg  <= status_next;
        end
    end

endmodule

FILE: hdl/vdp_checker.sv
// ---------------------------------------------------------------------------
// vdp_checker
// Port-level assertions for the host port, bound to the top level.
// ---------------------------------------------------------------------------
module vdp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [2:0] s_operation,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_reg_written,
    input logic [2:0] m_reg_number,
    input logic [7:0] m_reg_value
);
    import vdp_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // every accepted item yields a result next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item gave no result");

    // only a control write can complete a register write
    a_reg_only_ctrl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation != OP_CTRL_WR) |=> !m_reg_written)
        else $error("register write flagged for a non-control item");

    // register fields are zero unless a register was written
    a_reg_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_written |-> (m_reg_number == 3'd0) && (m_reg_value == 8'd0))
        else $error("register fields set without a register write");

endmodule

bind vdp_host_port_with_vram vdp_checker u_vdp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_operation   (s_operation),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_reg_written (m_reg_written),
    .m_reg_number  (m_reg_number),
    .m_reg_value   (m_reg_value)
);
